FILE: hw/rtl/sed_pkg.sv
package sed_pkg;

    // Position arithmetic
    localparam int POS_W      = 10;   // signed screen coordinate
    localparam int RAW_W      = 9;    // raw sprite coordinate
    localparam int TILE_W     = 14;
    localparam int COL_W      = 4;

    localparam logic [RAW_W-1:0] INV_BASE   = 9'd256;
    localparam logic [POS_W-1:0] TILE_SIZE  = 10'd16;
    localparam logic [POS_W-1:0] FLIP_BASE  = 10'd240;

    // APB register map
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_SCREEN_MIRROR = 1'b0;   // register index, taken from paddr[2]

    // Stream payload widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic [7:0] y_byte;
        logic [7:0] attr_byte;
        logic [7:0] tile_high_byte;
        logic [7:0] tile_low_byte;
        logic [7:0] x_byte;
    } entry_t;

    typedef struct packed {
        logic [TILE_W-1:0]       tile_number;
        logic [COL_W-1:0]        colour_bank;
        logic                    flip_x;
        logic                    flip_y;
        logic signed [POS_W-1:0] screen_x;
        logic signed [POS_W-1:0] screen_y;
        logic                    last_part;
    } cmd_t;

    typedef struct packed {
        logic enable;
        logic chain;
    } entry_ctl_t;

endpackage

FILE: hw/rtl/sed_decode.sv
// Combinational decode of one sprite entry into the draw command of one phase.
module sed_decode (
    input  sed_pkg::entry_t     entry,
    input  logic                screen_mirror,
    input  logic                phase,
    output sed_pkg::cmd_t       cmd,
    output sed_pkg::entry_ctl_t ctl
);

    logic [sed_pkg::RAW_W-1:0] y_raw;
    logic [sed_pkg::RAW_W-1:0] x_raw;
    logic [sed_pkg::RAW_W-1:0] y_inv;
    logic [sed_pkg::RAW_W-1:0] x_inv;
    logic [sed_pkg::POS_W-1:0] y_base;
    logic [sed_pkg::POS_W-1:0] x_base;
    logic [sed_pkg::POS_W-1:0] y_scr;
    logic [sed_pkg::POS_W-1:0] x_scr;
    logic [sed_pkg::POS_W-1:0] y_first;
    logic [sed_pkg::POS_W-1:0] y_second;
    logic                      fx;
    logic                      fy;
    logic                      chain;
    logic [sed_pkg::TILE_W-1:0] tile;

    always_comb
    begin
        y_raw  = {entry.attr_byte[2], entry.y_byte};
        x_raw  = {entry.attr_byte[3], entry.x_byte};
        y_inv  = sed_pkg::INV_BASE - y_raw;   // wraps mod 512
        x_inv  = sed_pkg::INV_BASE - x_raw;
        y_base = {1'b0, y_inv} - sed_pkg::TILE_SIZE;
        x_base = {1'b0, x_inv} - sed_pkg::TILE_SIZE;

        fx    = entry.tile_high_byte[7] ^ screen_mirror;
        fy    = entry.tile_high_byte[6] ^ screen_mirror;
        chain = entry.attr_byte[1];

        x_scr = screen_mirror ? (sed_pkg::FLIP_BASE - x_base) : x_base;
        y_scr = screen_mirror ? (sed_pkg::FLIP_BASE - y_base) : y_base;

        // first tile of a pair: the upper one, or the lower one when effective flip-y is set
        if (!fy)
        begin
            y_first  = screen_mirror ? y_scr : (y_scr - sed_pkg::TILE_SIZE);
            y_second = y_first + sed_pkg::TILE_SIZE;
        end
        else
        begin
            y_first  = screen_mirror ? (y_scr + sed_pkg::TILE_SIZE) : y_scr;
            y_second = y_first - sed_pkg::TILE_SIZE;
        end

        tile = {entry.tile_high_byte[5:0], entry.tile_low_byte};

        cmd.colour_bank = entry.attr_byte[7:4];
        cmd.flip_x      = fx;
        cmd.flip_y      = fy;
        cmd.screen_x    = x_scr;
        if (chain)
        begin
            cmd.tile_number = {tile[sed_pkg::TILE_W-1:1], phase};
            cmd.screen_y    = phase ? y_second : y_first;
            cmd.last_part   = phase;
        end
        else
        begin
            cmd.tile_number = tile;
            cmd.screen_y    = y_scr;
            cmd.last_part   = 1'b1;
        end

        ctl.enable = entry.attr_byte[0];
        ctl.chain  = chain;
    end

endmodule

FILE: hw/rtl/sprite_entry_decoder_unit.sv
// Sprite entry decoder. Each input beat is one five-byte sprite attribute
// entry; each output beat is one 16x16 tile draw command. A disabled entry
// gives no beat, a single entry one beat (tlast high), a chained entry two
// beats (even tile first, tlast on the odd tile). Entries sit in an input
// register, are decoded by short logic, and the command lands in a result
// register. A single or disabled entry leaves the input register once
// handled, so such entries stream at one per cycle (single ones only while
// m_tready is high); a chained entry holds it until both commands have gone,
// one at a time, through the single result register. The screen_mirror
// register (byte address 0) is to be written only while idle.
module sprite_entry_decoder_unit (
    input  logic                          clk,
    input  logic                          rst_n,

    // Entry stream. s_tdata, lowest bit up: y_byte[7:0], attr_byte[15:8],
    // tile_high_byte[23:16], tile_low_byte[31:24], x_byte[39:32]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sed_pkg::S_TDATA_W-1:0] s_tdata,

    // Command stream. m_tdata, lowest bit up: tile_number[13:0],
    // colour_bank[17:14], flip_x[18], flip_y[19], screen_x[29:20],
    // screen_y[39:30]. m_tlast is last_part.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sed_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast,

    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sed_pkg::ADDR_W-1:0]    paddr,
    input  logic [sed_pkg::DATA_W-1:0]    pwdata,
    output logic [sed_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    // Config register
    logic screen_mirror_reg;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == sed_pkg::REG_SCREEN_MIRROR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            screen_mirror_reg <= 1'b0;
        else if (cfg_write)
            screen_mirror_reg <= pwdata[0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == sed_pkg::REG_SCREEN_MIRROR)
            prdata[0] = screen_mirror_reg;
    end

    // Input stage: entry register plus pair phase
    sed_pkg::entry_t     entry_reg;
    logic                entry_valid_reg;
    logic                phase_reg;
    sed_pkg::cmd_t       cmd;
    sed_pkg::entry_ctl_t ctl;

    // Result register
    sed_pkg::cmd_t       out_reg;
    logic                out_valid_reg;

    logic stage_fire;   // input stage acts this cycle
    logic stage_done;   // entry fully handled, slot frees
    logic emit;         // a command moves into the result register

    sed_decode u_decode (
        .entry         (entry_reg),
        .screen_mirror (screen_mirror_reg),
        .phase         (phase_reg),
        .cmd           (cmd),
        .ctl           (ctl)
    );

    // Disabled entries drain without waiting for the output side.
    assign stage_fire = entry_valid_reg && (!ctl.enable || !out_valid_reg || m_tready);
    assign emit       = stage_fire && ctl.enable;
    assign stage_done = stage_fire && (!ctl.enable || cmd.last_part);
    assign s_tready   = !entry_valid_reg || stage_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            phase_reg       <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                entry_valid_reg <= 1'b1;
            else if (stage_done)
                entry_valid_reg <= 1'b0;

            if (stage_done)
                phase_reg <= 1'b0;
            else if (emit)
                phase_reg <= 1'b1;   // first half of a pair went out
        end
    end

    // unpack the beat field by field: y_byte sits in the lowest bits
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            entry_reg.y_byte         <= s_tdata[7:0];
            entry_reg.attr_byte      <= s_tdata[15:8];
            entry_reg.tile_high_byte <= s_tdata[23:16];
            entry_reg.tile_low_byte  <= s_tdata[31:24];
            entry_reg.x_byte         <= s_tdata[39:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_reg <= cmd;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.last_part;
    assign m_tdata  = {out_reg.screen_y, out_reg.screen_x, out_reg.flip_y,
                       out_reg.flip_x, out_reg.colour_bank, out_reg.tile_number};

endmodule

FILE: hw/rtl/sed_checker.sv
module sed_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sed_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast,
    input logic                          pready
);

    // stalled command holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("command changed under stall");

    // first half of a pair carries the even tile
    a_pair_even: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !m_tdata[0])
        else $error("first tile of pair is odd");

    // second half follows at once with the odd tile of the same pair
    a_pair_next: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tlast && m_tdata[0]
            && (m_tdata[13:1] == $past(m_tdata[13:1]))
            && (m_tdata[29:14] == $past(m_tdata[29:14])))
        else $error("second tile of pair wrong or late");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind sprite_entry_decoder_unit sed_checker u_sed_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .pready   (pready)
);
